// ===== sv/pproj_pkg.sv =====
// pinhole projection package: widths, register indexes, shared types
// no dependencies; used by every other file of the block
`default_nettype none

package pproj_pkg;

  localparam int XW        = 32;      // field width
  localparam int DW        = 33;      // point minus eye
  localparam int PW        = 64;      // 32x32 product
  localparam int CW        = 65;      // cross product component
  localparam int PHW       = 66;      // 33x33 partial product
  localparam int NW        = 99;      // dot product sum, signed
  localparam int MW        = NW;      // magnitude of a dot product
  localparam int QW        = 33;      // quotient bits kept before saturation
  localparam int FRAC_DEF  = 16;
  localparam int FRONT_STG = 6;
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = 64;

  localparam logic [CFG_IW-1:0] REG_A_XY      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_A_Z_B_X   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_B_YZ      = 3'd2;
  localparam logic [CFG_IW-1:0] REG_C_XY      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_C_Z_EYE_X = 3'd4;
  localparam logic [CFG_IW-1:0] REG_EYE_YZ    = 3'd5;

  localparam logic [QW-1:0]        POS_LIM = 33'h0_7fff_ffff;
  localparam logic [QW-1:0]        NEG_LIM = 33'h0_8000_0000;
  localparam logic signed [XW-1:0] SAT_POS = 32'sh7fff_ffff;
  localparam logic signed [XW-1:0] SAT_NEG = 32'sh8000_0000;

  typedef logic [MW-1:0] mag_t;
  typedef logic [QW-1:0] quo_t;

  typedef struct packed {
    logic signed [XW-1:0] ax, ay, az;
    logic signed [XW-1:0] bx, by, bz;
    logic signed [XW-1:0] cx, cy, cz;
    logic signed [XW-1:0] ex, ey, ez;
  } cam_t;

  // lane 0 = u, lane 1 = v, lane 2 = inverse depth
  typedef struct packed {
    logic       vis;
    logic [2:0] neg;
  } side_t;

  typedef struct packed {
    logic                 visible;
    logic signed [XW-1:0] proj_u;
    logic signed [XW-1:0] proj_v;
    logic signed [XW-1:0] inv_depth;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/pproj_pt_if.sv =====
// point input channel: valid/ready and the world point
// depends on pproj_pkg
`default_nettype none

interface pproj_pt_if;
  import pproj_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] point_x;
  logic signed [XW-1:0] point_y;
  logic signed [XW-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

// ===== sv/pproj_res_if.sv =====
// result channel: valid/ready and the projected point
// depends on pproj_pkg
`default_nettype none

interface pproj_res_if;
  import pproj_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 visible;
  logic signed [XW-1:0] proj_u;
  logic signed [XW-1:0] proj_v;
  logic signed [XW-1:0] inv_depth;

  modport source (output valid, visible, proj_u, proj_v, inv_depth, input ready);
  modport sink (input valid, visible, proj_u, proj_v, inv_depth, output ready);
endinterface

`default_nettype wire

// ===== sv/pproj_cfg_if.sv =====
// configuration write channel: valid/ready, register index and data
// depends on pproj_pkg
`default_nettype none

interface pproj_cfg_if;
  import pproj_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/pproj_cfg.sv =====
// camera register file, six 64-bit registers written over the config channel
// depends on pproj_pkg and pproj_cfg_if
`default_nettype none

module pproj_cfg (
  input  logic              clk,
  input  logic              rst_n,
  pproj_cfg_if.sink         cfg,
  output pproj_pkg::cam_t   cam
);
  import pproj_pkg::*;

  logic [CFG_DW-1:0] a_xy_r, a_z_b_x_r, b_yz_r, c_xy_r, c_z_eye_x_r, eye_yz_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_xy_r      <= '0;
      a_z_b_x_r   <= '0;
      b_yz_r      <= '0;
      c_xy_r      <= '0;
      c_z_eye_x_r <= '0;
      eye_yz_r    <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_A_XY:      a_xy_r      <= cfg.data;
        REG_A_Z_B_X:   a_z_b_x_r   <= cfg.data;
        REG_B_YZ:      b_yz_r      <= cfg.data;
        REG_C_XY:      c_xy_r      <= cfg.data;
        REG_C_Z_EYE_X: c_z_eye_x_r <= cfg.data;
        REG_EYE_YZ:    eye_yz_r    <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cam.ax = $signed(a_xy_r[63:32]);
    cam.ay = $signed(a_xy_r[31:0]);
    cam.az = $signed(a_z_b_x_r[63:32]);
    cam.bx = $signed(a_z_b_x_r[31:0]);
    cam.by = $signed(b_yz_r[63:32]);
    cam.bz = $signed(b_yz_r[31:0]);
    cam.cx = $signed(c_xy_r[63:32]);
    cam.cy = $signed(c_xy_r[31:0]);
    cam.cz = $signed(c_z_eye_x_r[63:32]);
    cam.ex = $signed(c_z_eye_x_r[31:0]);
    cam.ey = $signed(eye_yz_r[63:32]);
    cam.ez = $signed(eye_yz_r[31:0]);
  end

endmodule

`default_nettype wire

// ===== sv/pproj_front.sv =====
// six-stage front end: cross products, dot products, signs and magnitudes
// depends on pproj_pkg
`default_nettype none

module pproj_front (
  input  logic                           clk,
  input  logic                           adv,
  input  logic signed [pproj_pkg::XW-1:0] pt_x,
  input  logic signed [pproj_pkg::XW-1:0] pt_y,
  input  logic signed [pproj_pkg::XW-1:0] pt_z,
  input  pproj_pkg::cam_t                cam,
  output pproj_pkg::mag_t                mag [3],
  output pproj_pkg::mag_t                den,
  output pproj_pkg::side_t               side
);
  import pproj_pkg::*;

  logic signed [XW-1:0]  va [3], vb [3], vc [3], ve [3], vp [3];
  logic signed [XW-1:0]  xs [3][3], ys [3][3];

  logic signed [PW-1:0]  pp_nxt [9][2], pp_r [9][2];
  logic signed [DW-1:0]  d1_nxt [3], d1_r [3], d2_r [3];
  logic signed [CW-1:0]  cr_nxt [9], cr_r [9];
  logic signed [PHW-1:0] ph_nxt [12], pl_nxt [12], ph_r [12], pl_r [12];
  logic signed [NW-1:0]  prod_nxt [12], prod_r [12];
  logic signed [NW-1:0]  s_nxt [4], s_r [4];
  mag_t                  mag_nxt [3], mag_r [3];
  mag_t                  den_nxt, den_r;
  side_t                 side_nxt, side_r;

  always_comb begin
    va[0] = cam.ax; va[1] = cam.ay; va[2] = cam.az;
    vb[0] = cam.bx; vb[1] = cam.by; vb[2] = cam.bz;
    vc[0] = cam.cx; vc[1] = cam.cy; vc[2] = cam.cz;
    ve[0] = cam.ex; ve[1] = cam.ey; ve[2] = cam.ez;
    vp[0] = pt_x;   vp[1] = pt_y;   vp[2] = pt_z;
    for (int j = 0; j < 3; j++) begin
      // b x c, c x a, a x b
      xs[0][j] = vb[j]; ys[0][j] = vc[j];
      xs[1][j] = vc[j]; ys[1][j] = va[j];
      xs[2][j] = va[j]; ys[2][j] = vb[j];
    end
  end

  // stage 1: the 18 cross product terms, point minus eye
  always_comb begin
    int p, m;
    p = 0;
    m = 0;
    for (int v = 0; v < 3; v++) begin
      for (int j = 0; j < 3; j++) begin
        p = (j + 1) % 3;
        m = (j + 2) % 3;
        pp_nxt[3*v+j][0] = xs[v][p] * ys[v][m];
        pp_nxt[3*v+j][1] = xs[v][m] * ys[v][p];
      end
    end
    for (int j = 0; j < 3; j++) begin
      d1_nxt[j] = DW'(vp[j]) - DW'(ve[j]);
    end
  end

  // stage 2: cross components
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cr_nxt[k] = CW'(pp_r[k][0]) - CW'(pp_r[k][1]);
    end
  end

  // stage 3: each cross component split in a signed high and unsigned low word
  always_comb begin
    logic signed [DW-1:0] mop;
    int ci;
    mop = '0;
    ci  = 0;
    for (int k = 0; k < 12; k++) begin
      if (k < 3) begin
        ci  = k;
        mop = DW'(va[k]);
      end else begin
        ci  = k - 3;
        mop = d2_r[(k-3)%3];
      end
      ph_nxt[k] = $signed(cr_r[ci][CW-1:32]) * mop;
      pl_nxt[k] = $signed({1'b0, cr_r[ci][31:0]}) * mop;
    end
  end

  // stage 4: recombine partial products
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      prod_nxt[k] = (NW'(ph_r[k]) <<< 32) + NW'(pl_r[k]);
    end
  end

  // stage 5: det, n0, n1, n2
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s_nxt[i] = prod_r[3*i] + prod_r[3*i+1] + prod_r[3*i+2];
    end
  end

  // stage 6: visibility, quotient signs, magnitudes
  always_comb begin
    side_nxt.vis = (s_r[0] != '0) && (s_r[3] != '0) && (s_r[0][NW-1] == s_r[3][NW-1]);
    side_nxt.neg[0] = s_r[1][NW-1] ^ s_r[3][NW-1];
    side_nxt.neg[1] = s_r[2][NW-1] ^ s_r[3][NW-1];
    side_nxt.neg[2] = s_r[0][NW-1] ^ s_r[3][NW-1];
    mag_nxt[0] = MW'(s_r[1][NW-1] ? -s_r[1] : s_r[1]);
    mag_nxt[1] = MW'(s_r[2][NW-1] ? -s_r[2] : s_r[2]);
    mag_nxt[2] = MW'(s_r[0][NW-1] ? -s_r[0] : s_r[0]);
    den_nxt    = MW'(s_r[3][NW-1] ? -s_r[3] : s_r[3]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_r   <= pp_nxt;
      d1_r   <= d1_nxt;
      cr_r   <= cr_nxt;
      d2_r   <= d1_r;
      ph_r   <= ph_nxt;
      pl_r   <= pl_nxt;
      prod_r <= prod_nxt;
      s_r    <= s_nxt;
      mag_r  <= mag_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign mag  = mag_r;
  assign den  = den_r;
  assign side = side_r;

endmodule

`default_nettype wire

// ===== sv/pproj_div.sv =====
// pipelined restoring divider, three lanes sharing one divisor
// one overflow stage then one quotient bit per stage; depends on pproj_pkg
`default_nettype none

module pproj_div #(
  parameter int FRAC_BITS = pproj_pkg::FRAC_DEF
) (
  input  logic              clk,
  input  logic              adv,
  input  pproj_pkg::mag_t   mag_in [3],
  input  pproj_pkg::mag_t   den_in,
  input  pproj_pkg::side_t  side_in,
  output pproj_pkg::quo_t   q_out [3],
  output logic [2:0]        sat_out,
  output pproj_pkg::side_t  side_out
);
  import pproj_pkg::*;

  localparam int RW   = MW + QW + FRAC_BITS;
  localparam int DSTG = QW + 1;

  logic [RW-1:0] rem_r [DSTG][3];
  logic [QW-1:0] q_r   [DSTG][3];
  logic [2:0]    sat_r [DSTG];
  mag_t          den_r [DSTG];
  side_t         side_r [DSTG];

  always_ff @(posedge clk) begin
    if (adv) begin
      // overflow check: quotient would need more than QW bits
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= RW'(mag_in[l]) << FRAC_BITS;
        sat_r[0][l] <= (RW'(mag_in[l]) << FRAC_BITS) >= (RW'(den_in) << QW);
        q_r[0][l]   <= '0;
      end
      den_r[0]  <= den_in;
      side_r[0] <= side_in;
      // quotient bit QW-k at stage k
      for (int k = 1; k < DSTG; k++) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_r[k-1][l] >= (RW'(den_r[k-1]) << (QW - k))) begin
            rem_r[k][l] <= rem_r[k-1][l] - (RW'(den_r[k-1]) << (QW - k));
            q_r[k][l]   <= q_r[k-1][l] | (QW'(1) << (QW - k));
          end else begin
            rem_r[k][l] <= rem_r[k-1][l];
            q_r[k][l]   <= q_r[k-1][l];
          end
        end
        sat_r[k]  <= sat_r[k-1];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign q_out    = q_r[DSTG-1];
  assign sat_out  = sat_r[DSTG-1];
  assign side_out = side_r[DSTG-1];

endmodule

`default_nettype wire

// ===== sv/pproj_out.sv =====
// output stage: sign, saturation and not-visible zeroing, registered
// depends on pproj_pkg
`default_nettype none

module pproj_out (
  input  logic              clk,
  input  logic              adv,
  input  pproj_pkg::quo_t   q_in [3],
  input  logic [2:0]        sat_in,
  input  pproj_pkg::side_t  side_in,
  output pproj_pkg::res_t   res
);
  import pproj_pkg::*;

  logic signed [XW-1:0] lv [3];
  res_t                 res_nxt, res_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!side_in.vis) begin
        lv[l] = '0;
      end else if (!side_in.neg[l]) begin
        lv[l] = (sat_in[l] || (q_in[l] > POS_LIM)) ? SAT_POS : $signed(q_in[l][XW-1:0]);
      end else begin
        lv[l] = (sat_in[l] || (q_in[l] > NEG_LIM)) ? SAT_NEG
                                                  : $signed(XW'(0) - q_in[l][XW-1:0]);
      end
    end
    res_nxt.visible   = side_in.vis;
    res_nxt.proj_u    = lv[0];
    res_nxt.proj_v    = lv[1];
    res_nxt.inv_depth = lv[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== sv/pinhole_point_projection_top.sv =====
// data path: front end, divider and output register; throughput: one point per
// cycle while the skid register is empty, set by the fully pipelined multiplier
// and divider stages; one skid register lets one more point in while a result waits
// reset: rst_n synchronous active low, clears valid bits, skid flag and all six
// camera registers (the zero camera is singular, so every point reads not visible)
`default_nettype none

module pinhole_point_projection_top #(
  parameter int FRAC_BITS = pproj_pkg::FRAC_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pproj_pt_if.sink     in_if,
  pproj_res_if.source  out_if,
  pproj_cfg_if.sink    cfg_if
);
  import pproj_pkg::*;

  // pipeline depth: front end, overflow stage plus one stage per quotient bit, output
  localparam int NSTG = FRONT_STG + QW + 2;

  logic            adv;            // whole pipeline moves one stage
  logic [NSTG-1:0] v_r;            // valid bit of each stage
  logic            skid_full_r;
  res_t            skid_r;
  res_t            res;

  cam_t            cam;
  mag_t            mag [3];
  mag_t            den;
  side_t           side_f, side_d;
  quo_t            q [3];
  logic [2:0]      sat;

  // camera registers
  pproj_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_if),
    .cam   (cam)
  );

  // cross and dot products, signs and magnitudes
  pproj_front u_front (
    .clk  (clk),
    .adv  (adv),
    .pt_x (in_if.point_x),
    .pt_y (in_if.point_y),
    .pt_z (in_if.point_z),
    .cam  (cam),
    .mag  (mag),
    .den  (den),
    .side (side_f)
  );

  // three quotients by the depth numerator n2
  pproj_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .adv      (adv),
    .mag_in   (mag),
    .den_in   (den),
    .side_in  (side_f),
    .q_out    (q),
    .sat_out  (sat),
    .side_out (side_d)
  );

  // signed, saturated results
  pproj_out u_out (
    .clk     (clk),
    .adv     (adv),
    .q_in    (q),
    .sat_in  (sat),
    .side_in (side_d),
    .res     (res)
  );

  // the pipeline moves as long as the skid register is free; a result that is
  // not taken drops into the skid register and the pipeline stops behind it
  assign adv         = !skid_full_r;
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      skid_full_r <= 1'b0;
    end else begin
      if (adv) begin
        v_r <= {v_r[NSTG-2:0], in_if.valid};
      end
      if (skid_full_r) begin
        if (out_if.ready) begin
          skid_full_r <= 1'b0;
        end
      end else if (v_r[NSTG-1] && !out_if.ready) begin
        skid_full_r <= 1'b1;
      end
    end
  end

  // skid payload follows the last stage until it holds a waiting result
  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_r <= res;
    end
  end

  // result transfer comes from the skid register first
  assign out_if.valid     = skid_full_r || v_r[NSTG-1];
  assign out_if.visible   = skid_full_r ? skid_r.visible   : res.visible;
  assign out_if.proj_u    = skid_full_r ? skid_r.proj_u    : res.proj_u;
  assign out_if.proj_v    = skid_full_r ? skid_r.proj_v    : res.proj_v;
  assign out_if.inv_depth = skid_full_r ? skid_r.inv_depth : res.inv_depth;

endmodule

`default_nettype wire

// ===== sv/pproj_chk.sv =====
// port-level checker for the projection block, bound to the top level
// depends on pproj_pkg
`default_nettype none

module pproj_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           visible,
  input logic signed [pproj_pkg::XW-1:0] proj_u,
  input logic signed [pproj_pkg::XW-1:0] proj_v,
  input logic signed [pproj_pkg::XW-1:0] inv_depth
);
  import pproj_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(visible) && $stable(proj_u)
                               && $stable(proj_v) && $stable(inv_depth))
    else $error("result changed while stalled");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !visible |-> proj_u == '0 && proj_v == '0 && inv_depth == '0)
    else $error("hidden point with nonzero fields");

  a_depth_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && visible |-> !inv_depth[XW-1])
    else $error("visible point with negative inverse depth");

endmodule

bind pinhole_point_projection_top pproj_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .visible   (out_if.visible),
  .proj_u    (out_if.proj_u),
  .proj_v    (out_if.proj_v),
  .inv_depth (out_if.inv_depth)
);

`default_nettype wire

// ===== dv/pproj_scoreboard.sv =====
// scoreboard for the pinhole projection block: predicts each result from the
// camera registers written so far and checks the result channel in order
// depends on pproj_pkg and the three channel interfaces
`default_nettype none

module pproj_scoreboard (
  input  logic  clk,
  input  logic  rst_n,
  pproj_pt_if   pt,
  pproj_res_if  res,
  pproj_cfg_if  cfg,
  output int    errors,
  output int    pending,
  output int    n_visible,
  output int    n_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import pproj_pkg::*;

  localparam int FRAC = FRAC_DEF;
  typedef logic signed [127:0] wide_t;

  cam_t camera;
  res_t projections[$];

  function automatic logic signed [XW-1:0] ratio_sat(wide_t num, wide_t den);
    logic         neg;
    logic [127:0] mag_n, mag_d, quo;
    neg   = (num < 0) != (den < 0);
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    quo   = (mag_n << FRAC) / mag_d;
    if (!neg) return (quo > 128'h7fff_ffff) ? SAT_POS : quo[31:0];
    if (quo > 128'h8000_0000) return SAT_NEG;
    return -quo[31:0];
  endfunction

  function automatic res_t project(cam_t c, logic signed [XW-1:0] px,
                                   logic signed [XW-1:0] py, logic signed [XW-1:0] pz);
    wide_t ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz;
    wide_t bc0, bc1, bc2, ca0, ca1, ca2, ab0, ab1, ab2, det, n0, n1, n2;
    res_t  r;
    ax = c.ax; ay = c.ay; az = c.az;
    bx = c.bx; by = c.by; bz = c.bz;
    cx = c.cx; cy = c.cy; cz = c.cz;
    dx = wide_t'(px) - wide_t'(c.ex);
    dy = wide_t'(py) - wide_t'(c.ey);
    dz = wide_t'(pz) - wide_t'(c.ez);
    bc0 = by*cz - bz*cy; bc1 = bz*cx - bx*cz; bc2 = bx*cy - by*cx;
    ca0 = cy*az - cz*ay; ca1 = cz*ax - cx*az; ca2 = cx*ay - cy*ax;
    ab0 = ay*bz - az*by; ab1 = az*bx - ax*bz; ab2 = ax*by - ay*bx;
    det = bc0*ax + bc1*ay + bc2*az;
    n0  = bc0*dx + bc1*dy + bc2*dz;
    n1  = ca0*dx + ca1*dy + ca2*dz;
    n2  = ab0*dx + ab1*dy + ab2*dz;
    r = '0;
    if (det != 0 && n2 != 0 && ((det < 0) == (n2 < 0))) begin
      r.visible   = 1'b1;
      r.proj_u    = ratio_sat(n0, n2);
      r.proj_v    = ratio_sat(n1, n2);
      r.inv_depth = ratio_sat(det, n2);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      camera <= '0;
      projections.delete();
      errors <= 0;
      pending <= 0;
      n_visible <= 0;
      n_results <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_A_XY:      {camera.ax, camera.ay} <= cfg.data;
          REG_A_Z_B_X:   {camera.az, camera.bx} <= cfg.data;
          REG_B_YZ:      {camera.by, camera.bz} <= cfg.data;
          REG_C_XY:      {camera.cx, camera.cy} <= cfg.data;
          REG_C_Z_EYE_X: {camera.cz, camera.ex} <= cfg.data;
          REG_EYE_YZ:    {camera.ey, camera.ez} <= cfg.data;
          default: ;
        endcase
      end
      if (pt.valid && pt.ready)
        projections.push_back(project(camera, pt.point_x, pt.point_y, pt.point_z));
      if (res.valid && res.ready) begin
        n_results <= n_results + 1;
        if (projections.size() == 0) begin
          $display("%0t: unexpected result vis=%0b u=%h v=%h w=%h", $time,
                   res.visible, res.proj_u, res.proj_v, res.inv_depth);
          errors <= errors + 1;
        end else begin
          want = projections.pop_front();
          if (want.visible) n_visible <= n_visible + 1;
          if (res.visible !== want.visible || res.proj_u !== want.proj_u ||
              res.proj_v !== want.proj_v || res.inv_depth !== want.inv_depth) begin
            $display("%0t: mismatch exp vis=%0b u=%h v=%h w=%h got vis=%0b u=%h v=%h w=%h",
                     $time, want.visible, want.proj_u, want.proj_v, want.inv_depth,
                     res.visible, res.proj_u, res.proj_v, res.inv_depth);
            errors <= errors + 1;
          end
        end
      end
      // queue depth after this edge's push and pop, read by the stimulus side
      pending <= projections.size();
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_pinhole_point_projection_top.sv =====
// testbench top for pinhole_point_projection_top: drives points with random gaps
// and camera writes, leaves checking to pproj_scoreboard
// depends on pproj_pkg, the channel interfaces, the block and the scoreboard
`default_nettype none

module tb_pinhole_point_projection_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pproj_pkg::*;

  localparam int  PHASES      = 8;
  localparam int  PHASE_PTS   = 215;
  localparam int  DRAIN_WAIT  = 60;   // past the block's latency
  localparam int  CYCLE_LIMIT = 600000;
  localparam logic [XW-1:0] ONE = 32'h0001_0000;

  logic clk;
  logic rst_n;
  int   errors, pending, n_visible, n_results;
  int   cycles;
  int   n_points;
  int   n_writes;
  bit   burst;    // no idling on either side while set

  pproj_pt_if  pt_if ();
  pproj_res_if res_if ();
  pproj_cfg_if cfg_if ();

  pinhole_point_projection_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pt_if),
    .out_if (res_if),
    .cfg_if (cfg_if)
  );

  pproj_scoreboard u_scoreboard (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt        (pt_if),
    .res       (res_if),
    .cfg       (cfg_if),
    .errors    (errors),
    .pending   (pending),
    .n_visible (n_visible),
    .n_results (n_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // random values: mostly small so points land in view, some full range and corners
  function automatic logic [XW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          default: return ONE;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // basis a, b, c then eye
  task automatic set_camera(logic [XW-1:0] v[12]);
    write_reg(REG_A_XY,      {v[0], v[1]});
    write_reg(REG_A_Z_B_X,   {v[2], v[3]});
    write_reg(REG_B_YZ,      {v[4], v[5]});
    write_reg(REG_C_XY,      {v[6], v[7]});
    write_reg(REG_C_Z_EYE_X, {v[8], v[9]});
    write_reg(REG_EYE_YZ,    {v[10], v[11]});
  endtask

  task automatic send_point(logic [XW-1:0] x, logic [XW-1:0] y, logic [XW-1:0] z);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    pt_if.point_z <= z;
    do @(posedge clk); while (!pt_if.ready);
    n_points++;
  endtask

  // stop sending and let every outstanding projection come back
  task automatic drain();
    pt_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // result side stalls
  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  initial begin
    logic [XW-1:0] cam[12];
    logic [XW-1:0] m;
    int kind;
    cycles = 0;
    n_points = 0;
    n_writes = 0;
    burst = 1'b0;
    rst_n = 1'b0;
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero camera after reset is singular, nothing visible
    send_point(ONE, ONE, ONE);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    drain();

    // identity camera, eye at origin
    cam = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0};
    set_camera(cam);
    // out of range indexes must leave the camera alone
    write_reg(3'd6, 64'hffff_ffff_ffff_ffff);
    write_reg(3'd7, 64'h1234_5678_9abc_def0);
    send_point(0, 0, ONE);                        // straight ahead
    send_point(ONE, 32'hffff_0000, ONE);
    send_point(0, 0, 0);                          // point at the eye
    send_point(ONE, ONE, 32'hffff_0000);          // behind the camera
    send_point(32'h7fff_ffff, 32'h8000_0000, 1);  // saturates both ways
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_point(1, 1, 32'h8000_0000);
    drain();

    // mirrored depth axis: negative determinant, visible for negative z
    cam = '{ONE, 0, 0, 0, ONE, 0, 0, 0, 32'hffff_0000, 0, 0, 0};
    set_camera(cam);
    send_point(ONE, ONE, 32'hffff_0000);
    send_point(ONE, ONE, ONE);
    drain();

    // extreme camera values with extreme eye
    cam = '{32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 32'h8000_0000,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    set_camera(cam);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(0, 0, 0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      kind = ph % 4;
      foreach (cam[i]) cam[i] = pick_coord();
      if (kind == 0) begin
        // near identity basis, random eye: most points visible
        m = $urandom_range(1, 4) << 16;
        cam[0] = m; cam[4] = m; cam[8] = m;
        cam[1] = 0; cam[2] = 0; cam[3] = 0; cam[5] = 0; cam[6] = 0; cam[7] = 0;
      end else if (kind == 3 && ph == 3) begin
        // degenerate: c repeats a
        cam[6] = cam[0]; cam[7] = cam[1]; cam[8] = cam[2];
      end
      set_camera(cam);
      burst = (ph % 3 == 1);
      for (int k = 0; k < PHASE_PTS; k++)
        send_point(pick_coord(), pick_coord(), pick_coord());
      drain();
      burst = 1'b0;
    end

    $display("covered %0d points over %0d camera writes, %0d results, %0d visible",
             n_points, n_writes, n_results, n_visible);
    $display("camera sets: zero, identity, mirrored, extreme, singular and random");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
